@@ hw/rtl/ripple_decal_vertex_age_defines.svh @@
// Assertion helpers shared by the RTL that checks itself.
`ifndef RIPPLE_DECAL_VERTEX_AGE_DEFINES_SVH
`define RIPPLE_DECAL_VERTEX_AGE_DEFINES_SVH

// Checked only out of reset.
`define RDVA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every edge, reset included.
`define RDVA_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ hw/rtl/rdva_pkg.sv @@
package rdva_pkg;

    localparam logic [1:0] MODE_DIFFUSE = 2'd0;
    localparam logic [1:0] MODE_ALPHA   = 2'd1;
    localparam logic [1:0] MODE_TEX1    = 2'd2;

    localparam logic [1:0] CFG_RAMP  = 2'd0;
    localparam logic [1:0] CFG_DECAY = 2'd1;
    localparam logic [1:0] CFG_LIFE  = 2'd2;

    localparam logic [30:0] RAMP_RESET  = 31'd65536;
    localparam logic [30:0] DECAY_RESET = 31'd327680;
    localparam logic [30:0] LIFE_RESET  = 31'd655360;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    // Sign info handed to the divider with each operand pair.
    typedef struct packed {
        logic num_neg;
        logic den_neg;
    } rdva_div_sgn_t;

    // Fields that ride alongside the arithmetic.
    typedef struct packed {
        logic              expired;
        logic [1:0]        mode;
        logic              last;
        logic [16:0]       opac;
        logic signed [32:0] ou_h;
        logic signed [32:0] ov_h;
    } rdva_side_t;

endpackage

@@ hw/rtl/rdva_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, saturating
// signed 32-bit result, registered after the last stage.
module rdva_div
    import rdva_pkg::*;
#(
    parameter int NW = 48,
    parameter int DW = 47
) (
    input  logic                 aclk,
    input  logic                 en,
    input  rdva_div_sgn_t        sgn,
    input  logic [NW-1:0]        num_mag,
    input  logic [DW-1:0]        den_mag,
    output logic signed [31:0]   quot
);

    logic [DW-1:0]  rem_reg [NW];
    logic [NW-1:0]  nq_reg  [NW];
    logic [DW-1:0]  den_reg [NW];
    rdva_div_sgn_t  sgn_reg [NW];
    logic           nz_reg  [NW];
    logic           dz_reg  [NW];

    for (genvar s = 0; s < NW; s++) begin : g_stage
        logic [DW-1:0]  rem_in;
        logic [NW-1:0]  nq_in;
        logic [DW-1:0]  den_in;
        rdva_div_sgn_t  sgn_in;
        logic           nz_in;
        logic           dz_in;
        logic [DW:0]    trial;
        logic [DW:0]    diff;

        if (s == 0) begin : g_first
            assign rem_in = '0;
            assign nq_in  = num_mag;
            assign den_in = den_mag;
            assign sgn_in = sgn;
            assign nz_in  = (num_mag == '0);
            assign dz_in  = (den_mag == '0);
        end else begin : g_rest
            assign rem_in = rem_reg[s-1];
            assign nq_in  = nq_reg[s-1];
            assign den_in = den_reg[s-1];
            assign sgn_in = sgn_reg[s-1];
            assign nz_in  = nz_reg[s-1];
            assign dz_in  = dz_reg[s-1];
        end

        assign trial = {rem_in, nq_in[NW-1]};
        assign diff  = trial - {1'b0, den_in};

        always_ff @(posedge aclk) begin
            if (en) begin
                if (!diff[DW]) begin
                    rem_reg[s] <= diff[DW-1:0];
                end else begin
                    rem_reg[s] <= trial[DW-1:0];
                end
                nq_reg[s]  <= {nq_in[NW-2:0], ~diff[DW]};
                den_reg[s] <= den_in;
                sgn_reg[s] <= sgn_in;
                nz_reg[s]  <= nz_in;
                dz_reg[s]  <= dz_in;
            end
        end
    end

    logic [NW-1:0] q_mag;
    logic          q_neg;
    assign q_mag = nq_reg[NW-1];
    assign q_neg = sgn_reg[NW-1].num_neg ^ sgn_reg[NW-1].den_neg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (nz_reg[NW-1]) begin
                quot <= 32'sd0;
            end else if (dz_reg[NW-1]) begin
                quot <= sgn_reg[NW-1].num_neg ? S32_MIN : S32_MAX;
            end else if (!q_neg) begin
                quot <= (q_mag > NW'(32'h7FFF_FFFF)) ? S32_MAX : $signed(q_mag[31:0]);
            end else begin
                quot <= (q_mag > NW'(32'h8000_0000)) ? S32_MIN : -$signed(q_mag[31:0]);
            end
        end
    end

endmodule

@@ hw/rtl/ripple_decal_vertex_age.sv @@
// Ripple decal vertex aging.
// Input channel s_*: one vertex per item, valid/ready. Output channel m_*:
// one result per item, same order. Configuration: cfg_we writes cfg_wdata
// into register cfg_addr (0 ramp, 1 decay, 2 life); other indexes ignored.
// Write configuration only while the pipeline is empty.
// Throughput: one item per cycle while the output is not stalled. The
// dividers are QW bits wide, QW = max(48, 32 + FRAC_BITS), and work
// one bit per stage; the depth is set by the dividers for attenuation and the
// two coordinate scales, with five stages ahead and four behind them.
// Reset clears the valid bits of every stage and loads the default
// ramp / decay / life times; results in flight are dropped.
// When m_valid is high and m_ready low the whole pipeline holds and
// s_ready drops in the same cycle; nothing is lost or repeated.
// s_ready = m_ready | ~m_valid, so a waiting result never blocks a new
// item once the receiver takes it.
`include "ripple_decal_vertex_age_defines.svh"

module ripple_decal_vertex_age
    import rdva_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                cfg_we,
    input  logic [1:0]          cfg_addr,
    input  logic [30:0]         cfg_wdata,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic [30:0]         s_time_now,
    input  logic [30:0]         s_birth_time,
    input  logic [16:0]         s_init_atten,
    input  logic signed [31:0]  s_scale_num_u,
    input  logic signed [31:0]  s_scale_rate_u,
    input  logic signed [31:0]  s_scale_num_v,
    input  logic signed [31:0]  s_scale_rate_v,
    input  logic signed [31:0]  s_orig_u,
    input  logic signed [31:0]  s_orig_v,
    input  logic [16:0]         s_orig_opacity,
    input  logic [1:0]          s_output_mode,
    input  logic                s_last_vertex,

    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_expired,
    output logic [31:0]         m_diffuse_word,
    output logic [7:0]          m_alpha_byte,
    output logic signed [31:0]  m_tex0_u,
    output logic signed [31:0]  m_tex0_v,
    output logic [16:0]         m_tex1_u,
    output logic                m_last_out
);

    localparam int QW   = (32 + FRAC_BITS > 48) ? 32 + FRAC_BITS : 48;
    localparam int DENW = 64 - FRAC_BITS;
    localparam int DW   = DENW - 1;
    localparam int LAT  = QW + 10;
    localparam int BSW  = FRAC_BITS + 8;
    localparam int OPW  = FRAC_BITS + 2;
    localparam int BPW  = OPW + BSW;

    localparam logic signed [32:0] HALF33   = 33'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [64:0] HALF65   = 65'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [63:0] ONE64    = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [49:0] OPC_CAP  = 50'sd1 <<< (FRAC_BITS + 1);
    localparam logic signed [49:0] TEX1_MAX = 50'sd131071;
    localparam logic signed [64:0] MAX65    = 65'sd2147483647;
    localparam logic signed [64:0] MIN65    = -65'sd2147483648;
    localparam logic [BSW-1:0] BYTE_SCALE =
        BSW'((64'd25599 << FRAC_BITS) / 64'd100);

    // ---------------- configuration ----------------
    logic [30:0] ramp_reg, decay_reg, life_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ramp_reg  <= RAMP_RESET;
            decay_reg <= DECAY_RESET;
            life_reg  <= LIFE_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_RAMP:  ramp_reg  <= cfg_wdata;
                CFG_DECAY: decay_reg <= cfg_wdata;
                CFG_LIFE:  life_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    logic [LAT-1:0] vld_reg;
    logic           en;

    assign en      = !(vld_reg[LAT-1] && !m_ready);
    assign s_ready = en;
    assign m_valid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
        end
    end

    // ---------------- P1: age ----------------
    logic signed [31:0] age1_reg;
    logic [16:0]        init1_reg;
    logic signed [31:0] nu1_reg, ru1_reg, nv1_reg, rv1_reg;
    rdva_side_t         side1_reg, side1_next;

    always_comb begin
        side1_next.expired = 1'b0;
        side1_next.mode    = s_output_mode;
        side1_next.last    = s_last_vertex;
        side1_next.opac    = s_orig_opacity;
        side1_next.ou_h    = {s_orig_u[31], s_orig_u} - HALF33;
        side1_next.ov_h    = {s_orig_v[31], s_orig_v} - HALF33;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            age1_reg  <= $signed({1'b0, s_time_now}) - $signed({1'b0, s_birth_time});
            init1_reg <= s_init_atten;
            nu1_reg   <= s_scale_num_u;
            ru1_reg   <= s_scale_rate_u;
            nv1_reg   <= s_scale_num_v;
            rv1_reg   <= s_scale_rate_v;
            side1_reg <= side1_next;
        end
    end

    // ---------------- P2: envelope compares ----------------
    logic signed [31:0] age2_reg;
    logic [16:0]        init2_reg;
    logic signed [31:0] nu2_reg, ru2_reg, nv2_reg, rv2_reg;
    logic               ramp2_reg, decay2_reg;
    logic signed [32:0] lma2_reg;
    logic signed [31:0] lmd2_reg;
    rdva_side_t         side2_reg, side2_next;

    always_comb begin
        side2_next         = side1_reg;
        side2_next.expired = (age1_reg >= $signed({1'b0, life_reg}));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            age2_reg   <= age1_reg;
            init2_reg  <= init1_reg;
            nu2_reg    <= nu1_reg;
            ru2_reg    <= ru1_reg;
            nv2_reg    <= nv1_reg;
            rv2_reg    <= rv1_reg;
            ramp2_reg  <= (age1_reg < $signed({1'b0, ramp_reg}));
            decay2_reg <= (age1_reg > $signed({1'b0, decay_reg}));
            lma2_reg   <= $signed({2'b00, life_reg}) - {age1_reg[31], age1_reg};
            lmd2_reg   <= $signed({1'b0, life_reg}) - $signed({1'b0, decay_reg});
            side2_reg  <= side2_next;
        end
    end

    // ---------------- P3: products ----------------
    logic signed [49:0] an3_reg;
    logic [30:0]        ad3_reg;
    logic signed [63:0] pu3_reg, pv3_reg;
    logic signed [31:0] nu3_reg, nv3_reg;
    rdva_side_t         side3_reg;
    logic signed [31:0] amul;
    logic [30:0]        aden;

    // hold phase goes through the divider as init / 1
    always_comb begin
        if (ramp2_reg) begin
            amul = age2_reg;
            aden = ramp_reg;
        end else if (decay2_reg) begin
            amul = lma2_reg[31:0];
            aden = lmd2_reg[30:0];
        end else begin
            amul = 32'sd1;
            aden = 31'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            an3_reg   <= $signed({1'b0, init2_reg}) * amul;
            ad3_reg   <= aden;
            pu3_reg   <= age2_reg * ru2_reg;
            pv3_reg   <= age2_reg * rv2_reg;
            nu3_reg   <= nu2_reg;
            nv3_reg   <= nv2_reg;
            side3_reg <= side2_reg;
        end
    end

    // ---------------- P4: scale denominators ----------------
    logic signed [49:0]     an4_reg;
    logic [30:0]            ad4_reg;
    logic signed [DENW-1:0] du4_reg, dv4_reg;
    logic signed [31:0]     nu4_reg, nv4_reg;
    rdva_side_t             side4_reg;
    logic signed [63:0]     du_wide, dv_wide;

    assign du_wide = (pu3_reg >>> FRAC_BITS) + ONE64;
    assign dv_wide = (pv3_reg >>> FRAC_BITS) + ONE64;

    always_ff @(posedge aclk) begin
        if (en) begin
            an4_reg   <= an3_reg;
            ad4_reg   <= ad3_reg;
            du4_reg   <= $signed(du_wide[DENW-1:0]);
            dv4_reg   <= $signed(dv_wide[DENW-1:0]);
            nu4_reg   <= nu3_reg;
            nv4_reg   <= nv3_reg;
            side4_reg <= side3_reg;
        end
    end

    // ---------------- P5: sign / magnitude ----------------
    logic [QW-1:0]  am5_reg, num5_reg, nvm5_reg;
    logic [DW-1:0]  ad5_reg, dum5_reg, dvm5_reg;
    rdva_div_sgn_t  as5_reg, us5_reg, vs5_reg;
    rdva_side_t     side5_reg;
    logic [49:0]    an_abs;
    logic [31:0]    nu_abs, nv_abs;
    logic [DENW-1:0] du_abs, dv_abs;

    assign an_abs = an4_reg[49] ? 50'(-an4_reg) : 50'(an4_reg);
    assign nu_abs = nu4_reg[31] ? 32'(-nu4_reg) : 32'(nu4_reg);
    assign nv_abs = nv4_reg[31] ? 32'(-nv4_reg) : 32'(nv4_reg);
    assign du_abs = du4_reg[DENW-1] ? DENW'(-du4_reg) : DENW'(du4_reg);
    assign dv_abs = dv4_reg[DENW-1] ? DENW'(-dv4_reg) : DENW'(dv4_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            am5_reg   <= QW'(an_abs[47:0]);
            ad5_reg   <= DW'(ad4_reg);
            as5_reg   <= '{num_neg: an4_reg[49], den_neg: 1'b0};
            num5_reg  <= QW'({nu_abs, {FRAC_BITS{1'b0}}});
            dum5_reg  <= du_abs[DW-1:0];
            us5_reg   <= '{num_neg: nu4_reg[31], den_neg: du4_reg[DENW-1]};
            nvm5_reg  <= QW'({nv_abs, {FRAC_BITS{1'b0}}});
            dvm5_reg  <= dv_abs[DW-1:0];
            vs5_reg   <= '{num_neg: nv4_reg[31], den_neg: dv4_reg[DENW-1]};
            side5_reg <= side4_reg;
        end
    end

    // ---------------- dividers ----------------
    logic signed [31:0] atten_q, scale_u_q, scale_v_q;

    rdva_div #(.NW(QW), .DW(DW)) u_div_atten (
        .aclk    (aclk),
        .en      (en),
        .sgn     (as5_reg),
        .num_mag (am5_reg),
        .den_mag (ad5_reg),
        .quot    (atten_q)
    );

    rdva_div #(.NW(QW), .DW(DW)) u_div_u (
        .aclk    (aclk),
        .en      (en),
        .sgn     (us5_reg),
        .num_mag (num5_reg),
        .den_mag (dum5_reg),
        .quot    (scale_u_q)
    );

    rdva_div #(.NW(QW), .DW(DW)) u_div_v (
        .aclk    (aclk),
        .en      (en),
        .sgn     (vs5_reg),
        .num_mag (nvm5_reg),
        .den_mag (dvm5_reg),
        .quot    (scale_v_q)
    );

    rdva_side_t sdel_reg [QW+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            sdel_reg[0] <= side5_reg;
            for (int k = 1; k <= QW; k++) begin
                sdel_reg[k] <= sdel_reg[k-1];
            end
        end
    end

    // ---------------- D1: output products ----------------
    logic signed [49:0] opp1_reg;
    logic signed [64:0] tup1_reg, tvp1_reg;
    rdva_side_t         sd1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            opp1_reg <= $signed({1'b0, sdel_reg[QW].opac}) * atten_q;
            tup1_reg <= sdel_reg[QW].ou_h * scale_u_q;
            tvp1_reg <= sdel_reg[QW].ov_h * scale_v_q;
            sd1_reg  <= sdel_reg[QW];
        end
    end

    // ---------------- D2: shifts and clamps ----------------
    logic [OPW-1:0]     opc2_reg, opc2_next;
    logic [16:0]        tex1_2_reg, tex1_2_next;
    logic signed [31:0] tu2_reg, tu2_next, tv2_reg, tv2_next;
    rdva_side_t         sd2_reg;
    logic signed [49:0] op;
    logic signed [64:0] tu_sum, tv_sum;

    always_comb begin
        op     = opp1_reg >>> FRAC_BITS;
        tu_sum = (tup1_reg >>> FRAC_BITS) + HALF65;
        tv_sum = (tvp1_reg >>> FRAC_BITS) + HALF65;

        // past twice one the byte saturates anyway
        if (op <= 50'sd0) begin
            opc2_next = '0;
        end else if (op >= OPC_CAP) begin
            opc2_next = OPC_CAP[OPW-1:0];
        end else begin
            opc2_next = op[OPW-1:0];
        end

        if (op < 50'sd0) begin
            tex1_2_next = 17'd0;
        end else if (op > TEX1_MAX) begin
            tex1_2_next = 17'h1FFFF;
        end else begin
            tex1_2_next = op[16:0];
        end

        if (tu_sum > MAX65) begin
            tu2_next = S32_MAX;
        end else if (tu_sum < MIN65) begin
            tu2_next = S32_MIN;
        end else begin
            tu2_next = $signed(tu_sum[31:0]);
        end

        if (tv_sum > MAX65) begin
            tv2_next = S32_MAX;
        end else if (tv_sum < MIN65) begin
            tv2_next = S32_MIN;
        end else begin
            tv2_next = $signed(tv_sum[31:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            opc2_reg   <= opc2_next;
            tex1_2_reg <= tex1_2_next;
            tu2_reg    <= tu2_next;
            tv2_reg    <= tv2_next;
            sd2_reg    <= sd1_reg;
        end
    end

    // ---------------- D3: byte product ----------------
    logic [BPW-1:0]     bp3_reg;
    logic [16:0]        tex1_3_reg;
    logic signed [31:0] tu3_reg, tv3_reg;
    rdva_side_t         sd3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            bp3_reg    <= BPW'(opc2_reg) * BPW'(BYTE_SCALE);
            tex1_3_reg <= tex1_2_reg;
            tu3_reg    <= tu2_reg;
            tv3_reg    <= tv2_reg;
            sd3_reg    <= sd2_reg;
        end
    end

    // ---------------- D4: output register ----------------
    logic [9:0]         byte_hi;
    logic [7:0]         byte_val;
    logic [31:0]        diffuse_next;
    logic [7:0]         alpha_next;
    logic [16:0]        tex1_next;
    logic signed [31:0] tex0_u_next, tex0_v_next;

    assign byte_hi  = bp3_reg[2*FRAC_BITS+9:2*FRAC_BITS];
    assign byte_val = (byte_hi > 10'd255) ? 8'hFF : byte_hi[7:0];

    always_comb begin
        diffuse_next = 32'd0;
        alpha_next   = 8'd0;
        tex1_next    = 17'd0;
        tex0_u_next  = 32'sd0;
        tex0_v_next  = 32'sd0;
        if (!sd3_reg.expired) begin
            tex0_u_next = tu3_reg;
            tex0_v_next = tv3_reg;
            case (sd3_reg.mode)
                MODE_DIFFUSE: diffuse_next = {ALPHA_OPAQUE, byte_val, byte_val, byte_val};
                MODE_ALPHA:   alpha_next   = byte_val;
                MODE_TEX1:    tex1_next    = tex1_3_reg;
                default:      tex1_next    = tex1_3_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_last_out     <= sd3_reg.last;
            m_expired      <= sd3_reg.expired;
            m_diffuse_word <= diffuse_next;
            m_alpha_byte   <= alpha_next;
            m_tex1_u       <= tex1_next;
            m_tex0_u       <= tex0_u_next;
            m_tex0_v       <= tex0_v_next;
        end
    end

    // ---------------- checks ----------------
    `RDVA_ASSERT_RST(a_reset_flush, !aresetn |=> !m_valid, "valid survived reset")
    `RDVA_ASSERT(a_stall_blocks, (m_valid && !m_ready) |-> !s_ready, "item taken during stall")
    `RDVA_ASSERT(a_expired_zero, (m_valid && m_expired) |-> (m_diffuse_word == 32'd0 && m_alpha_byte == 8'd0 && m_tex1_u == 17'd0 && m_tex0_u == 32'sd0 && m_tex0_v == 32'sd0), "expired item carries data")
    `RDVA_ASSERT(a_diffuse_form, (m_valid && m_diffuse_word != 32'd0) |-> (m_diffuse_word[31:24] == ALPHA_OPAQUE && m_diffuse_word[7:0] == m_diffuse_word[15:8] && m_alpha_byte == 8'd0 && m_tex1_u == 17'd0), "diffuse word malformed")

endmodule
